>>> rtl/sit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted interval table package
// Command and status codes, controller states and the structs passed
// between the controller and the cell chain.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int CMD_W = 2;
	localparam int ST_W  = 3;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK                = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_WIDTH          = 3'd1;
	localparam logic [ST_W-1:0] ST_EXIT_BEFORE_ENTRY = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERLAP           = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL              = 3'd4;
	localparam logic [ST_W-1:0] ST_BAD_SLOT          = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	// table update and scan mode, broadcast to every cell
	typedef struct packed {
		logic ins_load;   // shift up above the insert point, load new interval
		logic rem_shift;  // shift down from the removed slot
		logic scan_rd;    // token picks up the selected slot's interval
	} cell_ctl_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic done;
		logic ovl;
	} tok_t;

endpackage
`default_nettype wire

>>> rtl/sit_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted interval table cell
// Holds one interval, shifts with its neighbors on insert and remove, and
// resolves the search token as it passes by.
// ----------------------------------------------------------------------------
module sit_cell #(
	parameter int MAX_INTERVALS = 16,
	parameter int INDEX_BITS    = 16,
	parameter int CELL_IDX      = 0,
	parameter int PW            = $clog2(MAX_INTERVALS + 1)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  sit_pkg::cell_ctl_t      ctl,
	input  wire  [PW-1:0]           cnt,
	input  wire  [PW-1:0]           pos_sel,
	input  wire  [INDEX_BITS-1:0]   new_entry,
	input  wire  [INDEX_BITS-1:0]   new_exit,
	input  wire  [INDEX_BITS-1:0]   left_entry,
	input  wire  [INDEX_BITS-1:0]   left_exit,
	input  wire  [INDEX_BITS-1:0]   right_entry,
	input  wire  [INDEX_BITS-1:0]   right_exit,
	output logic [INDEX_BITS-1:0]   cell_entry,
	output logic [INDEX_BITS-1:0]   cell_exit,
	input  sit_pkg::tok_t           tok_in,
	input  wire  [PW-1:0]           tok_in_where,
	input  wire  [INDEX_BITS-1:0]   tok_in_entry,
	input  wire  [INDEX_BITS-1:0]   tok_in_exit,
	output sit_pkg::tok_t           tok_out,
	output logic [PW-1:0]           tok_out_where,
	output logic [INDEX_BITS-1:0]   tok_out_entry,
	output logic [INDEX_BITS-1:0]   tok_out_exit
);
	import sit_pkg::*;

	localparam logic [PW-1:0] IDX = PW'(CELL_IDX);

	logic [INDEX_BITS-1:0] ent_q, ext_q;
	tok_t                  tok_q;
	logic [PW-1:0]         where_q;
	logic [INDEX_BITS-1:0] tok_ent_q, tok_ext_q;

	logic cell_valid, place, ovl;
	tok_t                  tok_nx;
	logic [PW-1:0]         where_nx;
	logic [INDEX_BITS-1:0] tok_ent_nx, tok_ext_nx;

	assign cell_valid = IDX < cnt;
	assign place = (new_entry < ent_q) && (new_exit <= ent_q);
	assign ovl = ((ent_q < new_entry) && (new_entry < ext_q)) ||
		((ent_q < new_exit) && (new_exit < ext_q)) ||
		((new_entry <= ent_q) && (ext_q <= new_exit));

	always_comb begin
		tok_nx     = tok_in;
		where_nx   = tok_in_where;
		tok_ent_nx = tok_in_entry;
		tok_ext_nx = tok_in_exit;
		if (tok_in.valid && !tok_in.done) begin
			if (ctl.scan_rd) begin
				if (IDX == pos_sel) begin
					tok_nx.done = 1'b1;
					tok_ent_nx  = ent_q;
					tok_ext_nx  = ext_q;
				end
			end else if (!cell_valid || place) begin
				// first free cell or first interval wholly after the new one
				tok_nx.done = 1'b1;
				where_nx    = IDX;
			end else if (ovl) begin
				tok_nx.done = 1'b1;
				tok_nx.ovl  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	always_ff @(posedge clk) begin
		where_q   <= where_nx;
		tok_ent_q <= tok_ent_nx;
		tok_ext_q <= tok_ext_nx;
		if (ctl.ins_load) begin
			if (IDX == pos_sel) begin
				ent_q <= new_entry;
				ext_q <= new_exit;
			end else if (IDX > pos_sel) begin
				ent_q <= left_entry;
				ext_q <= left_exit;
			end
		end else if (ctl.rem_shift && (IDX >= pos_sel)) begin
			ent_q <= right_entry;
			ext_q <= right_exit;
		end
	end

	assign cell_entry    = ent_q;
	assign cell_exit     = ext_q;
	assign tok_out       = tok_q;
	assign tok_out_where = where_q;
	assign tok_out_entry = tok_ent_q;
	assign tok_out_exit  = tok_ext_q;

endmodule
`default_nettype wire

>>> rtl/sorted_interval_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A well-formed insert or in-range read passes through S_SCAN, where the search token
//   walks the cell chain one cell per cycle, then S_FINISH and the output register.
// Remove, rejected and unused commands go from S_IDLE straight to S_FINISH.
// A new request is taken only once the controller is back in S_IDLE, and it is
//   taken while the previous result waits in the output register.
// Reset clears the count and control state; cell contents stay undefined.
// ----------------------------------------------------------------------------
// Sorted interval table top
// Controller, output register and a chain of interval cells.
// ----------------------------------------------------------------------------
module sorted_interval_table_top #(
	parameter int MAX_INTERVALS = 16,
	parameter int INDEX_BITS    = 16,
	localparam int SW     = $clog2(MAX_INTERVALS),
	localparam int PW     = $clog2(MAX_INTERVALS + 1),
	localparam int IN_W   = ((sit_pkg::CMD_W + 2 * INDEX_BITS + SW + 7) / 8) * 8,
	localparam int OUT_W  = ((sit_pkg::ST_W + 2 * PW + 2 * INDEX_BITS + 7) / 8) * 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_axis_tvalid,
	output logic             s_axis_tready,
	// command, entry_index, exit_index, slot
	input  wire  [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire              m_axis_tready,
	// status, position, read_entry, read_exit, count
	output logic [OUT_W-1:0] m_axis_tdata
);
	import sit_pkg::*;

	localparam int IB      = INDEX_BITS;
	localparam int OUT_RAW = ST_W + 2 * PW + 2 * IB;
	localparam logic [PW-1:0] MAX_CNT = PW'(MAX_INTERVALS);

	state_t              state_q;
	logic [PW-1:0]       cnt_q;
	logic                launch_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [IB-1:0]       ent_q, ext_q;
	logic [SW-1:0]       slot_q;
	logic [ST_W-1:0]     res_status_q;
	logic [PW-1:0]       res_pos_q;
	logic [IB-1:0]       res_rd_ent_q, res_rd_ext_q;

	logic [CMD_W-1:0]    in_cmd;
	logic [IB-1:0]       in_ent, in_ext;
	logic [SW-1:0]       in_slot;
	logic [ST_W-1:0]     in_status;
	logic [PW-1:0]       in_pos;
	logic                in_scan;
	logic                accept, fin_fire, upd_ok;
	logic [PW-1:0]       cnt_nx, pos_sel;
	logic [OUT_W-1:0]    out_pack;
	cell_ctl_t           ctl;

	tok_t                tok   [MAX_INTERVALS+1];
	logic [PW-1:0]       tok_w [MAX_INTERVALS+1];
	logic [IB-1:0]       tok_e [MAX_INTERVALS+1];
	logic [IB-1:0]       tok_x [MAX_INTERVALS+1];
	logic [IB-1:0]       cell_e [MAX_INTERVALS+2];
	logic [IB-1:0]       cell_x [MAX_INTERVALS+2];

	assign in_cmd  = s_axis_tdata[CMD_W-1:0];
	assign in_ent  = s_axis_tdata[CMD_W +: IB];
	assign in_ext  = s_axis_tdata[CMD_W + IB +: IB];
	assign in_slot = s_axis_tdata[CMD_W + 2 * IB +: SW];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign fin_fire = (state_q == S_FINISH) && (!out_valid_q || m_axis_tready);
	assign upd_ok   = fin_fire && (res_status_q == ST_OK);

	assign ctl.ins_load  = upd_ok && (cmd_q == CMD_INSERT);
	assign ctl.rem_shift = upd_ok && (cmd_q == CMD_REMOVE);
	assign ctl.scan_rd   = (cmd_q == CMD_READ);
	assign pos_sel = (cmd_q == CMD_INSERT) ? res_pos_q : PW'(slot_q);

	// early checks on the incoming request; a scan is needed only for a
	// well-formed insert or an in-range read
	always_comb begin
		in_status = ST_OK;
		in_pos    = '0;
		in_scan   = 1'b0;
		unique case (in_cmd) inside
			CMD_INSERT: begin
				if (in_ent == in_ext) begin
					in_status = ST_NO_WIDTH;
				end else if (in_ext < in_ent) begin
					in_status = ST_EXIT_BEFORE_ENTRY;
				end else begin
					in_scan = 1'b1;
				end
			end
			CMD_REMOVE, CMD_READ: begin
				in_pos = PW'(in_slot);
				if (!(PW'(in_slot) < cnt_q)) begin
					in_status = ST_BAD_SLOT;
				end else if (in_cmd == CMD_READ) begin
					in_scan = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cnt_nx = cnt_q;
		if (ctl.ins_load) begin
			cnt_nx = cnt_q + PW'(1);
		end else if (ctl.rem_shift) begin
			cnt_nx = cnt_q - PW'(1);
		end
	end

	always_comb begin
		out_pack = '0;
		out_pack[OUT_RAW-1:0] = {cnt_nx, res_rd_ext_q, res_rd_ent_q, res_pos_q, res_status_q};
	end

	// chain ends
	assign tok[0]    = '{valid: launch_q, done: 1'b0, ovl: 1'b0};
	assign tok_w[0]  = '0;
	assign tok_e[0]  = '0;
	assign tok_x[0]  = '0;
	assign cell_e[0] = '0;
	assign cell_x[0] = '0;
	assign cell_e[MAX_INTERVALS+1] = '0;
	assign cell_x[MAX_INTERVALS+1] = '0;

	for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
		sit_cell #(
			.MAX_INTERVALS(MAX_INTERVALS),
			.INDEX_BITS   (INDEX_BITS),
			.CELL_IDX     (g),
			.PW           (PW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.cnt          (cnt_q),
			.pos_sel      (pos_sel),
			.new_entry    (ent_q),
			.new_exit     (ext_q),
			.left_entry   (cell_e[g]),
			.left_exit    (cell_x[g]),
			.right_entry  (cell_e[g+2]),
			.right_exit   (cell_x[g+2]),
			.cell_entry   (cell_e[g+1]),
			.cell_exit    (cell_x[g+1]),
			.tok_in       (tok[g]),
			.tok_in_where (tok_w[g]),
			.tok_in_entry (tok_e[g]),
			.tok_in_exit  (tok_x[g]),
			.tok_out      (tok[g+1]),
			.tok_out_where(tok_w[g+1]),
			.tok_out_entry(tok_e[g+1]),
			.tok_out_exit (tok_x[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= accept && in_scan;
			if (fin_fire) begin
				out_valid_q <= 1'b1;
				cnt_q       <= cnt_nx;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= in_scan ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (tok[MAX_INTERVALS].valid) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= in_cmd;
			ent_q        <= in_ent;
			ext_q        <= in_ext;
			slot_q       <= in_slot;
			res_status_q <= in_status;
			res_pos_q    <= in_pos;
			res_rd_ent_q <= '0;
			res_rd_ext_q <= '0;
		end else if ((state_q == S_SCAN) && tok[MAX_INTERVALS].valid) begin
			if (cmd_q == CMD_READ) begin
				res_rd_ent_q <= tok_e[MAX_INTERVALS];
				res_rd_ext_q <= tok_x[MAX_INTERVALS];
			end else if (tok[MAX_INTERVALS].ovl) begin
				res_status_q <= ST_OVERLAP;
			end else if (cnt_q == MAX_CNT) begin
				res_status_q <= ST_FULL;
			end else begin
				res_pos_q <= tok_w[MAX_INTERVALS];
			end
		end
		if (fin_fire) begin
			out_data_q <= out_pack;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_INTERVALS].valid |-> (state_q == S_SCAN))
		else $error("search token left the chain outside a scan");

	a_launch_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> (state_q == S_SCAN))
		else $error("token launched outside a scan");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("interval count above table size");

	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_FINISH))
		else $error("count changed outside result delivery");

endmodule
`default_nettype wire

>>> tb/sorted_interval_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted interval table testbench
// Drives insert, remove and read requests into the table over the request
// stream. A shadow copy of the table predicts every response, and each
// response is checked field by field. The directed requests come first, then
// four random phases with different idle and stall rates.
// ----------------------------------------------------------------------------
module sorted_interval_table_top_tb;
	import sit_pkg::*;

	localparam int MAXN  = 16;
	localparam int IDX_W = 16;
	localparam int IN_W  = ((CMD_W + 2 * IDX_W + 4 + 7) / 8) * 8;
	localparam int OUT_W = ((ST_W + 2 * 5 + 2 * IDX_W + 7) / 8) * 8;
	localparam int RANDOM_REQS = 800;

	typedef struct {
		logic [ST_W-1:0]  status;
		logic [4:0]       position;
		logic [IDX_W-1:0] rd_entry;
		logic [IDX_W-1:0] rd_exit;
		logic [4:0]       count;
	} table_resp_t;

	// shadow table, predicted responses and mismatch bookkeeping
	class interval_scoreboard;
		logic [IDX_W-1:0] ent [MAXN];
		logic [IDX_W-1:0] ext [MAXN];
		int               cnt;
		table_resp_t      pending_resp [$];
		int               errors;
		int               status_hits [8];
		int               n_insert, n_remove, n_read, n_none, n_full_table;

		function new();
			cnt = 0;
			errors = 0;
			n_insert = 0;
			n_remove = 0;
			n_read = 0;
			n_none = 0;
			n_full_table = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		task report_mismatch(input string what);
			errors++;
			$display("%0t ns: MISMATCH %s", $time, what);
		endtask

		function int pending();
			return pending_resp.size();
		endfunction

		function void note_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] en,
				input logic [IDX_W-1:0] ex, input logic [3:0] slot);
			table_resp_t r;
			int where;
			r.status = ST_OK;
			r.position = '0;
			r.rd_entry = '0;
			r.rd_exit = '0;
			if (cmd == CMD_INSERT) begin
				n_insert++;
				where = cnt;
				if (en == ex) r.status = ST_NO_WIDTH;
				else if (ex < en) r.status = ST_EXIT_BEFORE_ENTRY;
				else begin
					for (int i = 0; i < cnt; i++) begin
						if (en < ent[i] && ex <= ent[i]) begin
							where = i;
							break;
						end
						if ((ent[i] < en && en < ext[i]) || (ent[i] < ex && ex < ext[i]) ||
								(en <= ent[i] && ext[i] <= ex)) begin
							r.status = ST_OVERLAP;
							break;
						end
					end
					if (r.status == ST_OK && cnt >= MAXN) r.status = ST_FULL;
				end
				if (r.status == ST_OK) begin
					for (int i = cnt; i > where; i--) begin
						ent[i] = ent[i-1];
						ext[i] = ext[i-1];
					end
					ent[where] = en;
					ext[where] = ex;
					cnt++;
					r.position = where[4:0];
				end
			end else if (cmd == CMD_REMOVE || cmd == CMD_READ) begin
				if (cmd == CMD_REMOVE) n_remove++;
				else n_read++;
				r.position = {1'b0, slot};
				if (slot >= cnt) r.status = ST_BAD_SLOT;
				else if (cmd == CMD_REMOVE) begin
					for (int i = slot; i + 1 < cnt; i++) begin
						ent[i] = ent[i+1];
						ext[i] = ext[i+1];
					end
					cnt--;
				end else begin
					r.rd_entry = ent[slot];
					r.rd_exit = ext[slot];
				end
			end else begin
				n_none++;
			end
			r.count = cnt[4:0];
			if (cnt == MAXN) n_full_table++;
			status_hits[r.status]++;
			pending_resp.insert(pending_resp.size(), r);
		endfunction

		task check_result(input logic [OUT_W-1:0] d);
			table_resp_t e;
			if (pending_resp.size() == 0) begin
				report_mismatch($sformatf("response with nothing outstanding: %h", d));
				return;
			end
			e = pending_resp.pop_front();
			if (d[2:0] !== e.status)
				report_mismatch($sformatf("status %0d, want %0d", d[2:0], e.status));
			if (d[7:3] !== e.position)
				report_mismatch($sformatf("position %0d, want %0d", d[7:3], e.position));
			if (d[23:8] !== e.rd_entry)
				report_mismatch($sformatf("read_entry %0d, want %0d", d[23:8], e.rd_entry));
			if (d[39:24] !== e.rd_exit)
				report_mismatch($sformatf("read_exit %0d, want %0d", d[39:24], e.rd_exit));
			if (d[44:40] !== e.count)
				report_mismatch($sformatf("count %0d, want %0d", d[44:40], e.count));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	interval_scoreboard sb = new();

	sorted_interval_table_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// response side: random back-pressure and checking
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] en,
			input logic [IDX_W-1:0] ex, input logic [3:0] slot);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		// now and then a long gap so idle time lands deep inside a search
		if (send_idle_pct > 0 && $urandom_range(0, 9) == 0) gap += $urandom_range(1, 25);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {2'b00, slot, ex, en, cmd};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(cmd, en, ex, slot);
	endtask

	task automatic send_random(input int insert_pct);
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] en, ex;
		logic [3:0]       slot;
		int r, k, base, lo;
		en = IDX_W'($urandom);
		ex = IDX_W'($urandom);
		slot = sb.cnt == 0 ? 4'd0 : 4'($urandom_range(0, sb.cnt - 1));
		if ($urandom_range(0, 4) == 0) slot = 4'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r < 3) cmd = CMD_NONE;
		else if (r < 3 + insert_pct) cmd = CMD_INSERT;
		else if ((r & 1) == 1) cmd = CMD_REMOVE;
		else cmd = CMD_READ;
		if (cmd == CMD_INSERT) begin
			r = $urandom_range(0, 99);
			if (r < 6) ex = en;
			else if (r < 12) begin
				en = IDX_W'($urandom_range(1, 65535));
				ex = IDX_W'($urandom_range(0, en - 1));
			end else if (r < 50 && sb.cnt > 0) begin
				// near a stored interval: touching ends and partial overlaps
				k = $urandom_range(0, sb.cnt - 1);
				base = $urandom_range(0, 1) ? sb.ent[k] : sb.ext[k];
				lo = base + $urandom_range(0, 1) * $urandom_range(0, 40)
					- $urandom_range(0, 1) * $urandom_range(0, 40);
				en = IDX_W'(lo);
				ex = IDX_W'(lo + $urandom_range(1, 300));
			end else if (r < 60) begin
				// anywhere in the index range, keeping exit above entry
				en = IDX_W'($urandom_range(0, 65534));
				ex = IDX_W'($urandom_range(en + 1, 65535));
			end else begin
				en = IDX_W'($urandom_range(0, 6000));
				ex = IDX_W'(en + $urandom_range(1, 400));
			end
		end
		send_request(cmd, en, ex, slot);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table, unused command, rejected inserts
		send_request(CMD_READ,   16'd0,     16'd0,     4'd0);
		send_request(CMD_REMOVE, 16'd0,     16'd0,     4'd15);
		send_request(CMD_NONE,   16'hFFFF,  16'hFFFF,  4'hF);
		send_request(CMD_INSERT, 16'd0,     16'd0,     4'd0);
		send_request(CMD_INSERT, 16'hFFFF,  16'd0,     4'd0);
		// touching ends on both sides
		send_request(CMD_INSERT, 16'd100,   16'd200,   4'd0);
		send_request(CMD_INSERT, 16'd200,   16'd300,   4'd0);
		send_request(CMD_INSERT, 16'd0,     16'd100,   4'd0);
		// overlaps: straddle, entry inside, contained, identical, covering all
		send_request(CMD_INSERT, 16'd150,   16'd250,   4'd0);
		send_request(CMD_INSERT, 16'd50,    16'd150,   4'd0);
		send_request(CMD_INSERT, 16'd120,   16'd180,   4'd0);
		send_request(CMD_INSERT, 16'd100,   16'd200,   4'd0);
		send_request(CMD_INSERT, 16'd0,     16'hFFFF,  4'd0);
		send_request(CMD_INSERT, 16'hFFFE,  16'hFFFF,  4'd0);
		send_request(CMD_INSERT, 16'd300,   16'hFFFE,  4'd0);
		send_request(CMD_READ,   16'd0,     16'd0,     4'd4);
		send_request(CMD_READ,   16'd0,     16'd0,     4'd0);
		send_request(CMD_READ,   16'd0,     16'd0,     4'd5);
		send_request(CMD_REMOVE, 16'd0,     16'd0,     4'd2);
		send_request(CMD_REMOVE, 16'd0,     16'd0,     4'd4);
		send_request(CMD_INSERT, 16'd250,   16'd260,   4'd0);
		send_request(CMD_REMOVE, 16'd0,     16'd0,     4'd0);
		send_request(CMD_READ,   16'd0,     16'd0,     4'd3);

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 61 : (ph == 3) ? 37 : 0;
			recv_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 37 : 0;
			for (int n = 0; n < RANDOM_REQS / 4; n++)
				send_random((ph % 2 == 0) ? 60 : 38);
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d inserts, %0d removes, %0d reads, %0d unused commands;",
			sb.n_insert, sb.n_remove, sb.n_read, sb.n_none);
		$display("status ok/nowidth/backward/overlap/full/badslot: %0d/%0d/%0d/%0d/%0d/%0d",
			sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
			sb.status_hits[3], sb.status_hits[4], sb.status_hits[5]);
		if (sb.errors == 0) begin
			$display("sorted_interval_table_top_tb OK");
		end else begin
			$display("sorted_interval_table_top_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d responses outstanding", sb.pending());
		$display("sorted_interval_table_top_tb NOT OK");
		$finish;
	end

endmodule
